// ===== design/diseqc_command_string_sequencer_assert.svh =====
`ifndef DISEQC_COMMAND_STRING_SEQUENCER_ASSERT_SVH
`define DISEQC_COMMAND_STRING_SEQUENCER_ASSERT_SVH

// Same-cycle implication, inactive while reset is held.
`define DCS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, inactive while reset is held.
`define DCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define DCS_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/dcs_pkg.sv =====
package dcs_pkg;

    // Sizing.
    localparam int MAX_CODES_DEF = 6;
    localparam int BUF_MAX       = 8;
    localparam int QUEUE_DEPTH   = 2;
    localparam int SLOTS         = 3;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;

    // SCR constants.
    localparam int          SCR_T_BASE  = 350;
    localparam int          SCR_T_LIMIT = 1024;
    localparam logic [7:0]  SCR_CMD_PIN = 8'h5C;
    localparam logic [7:0]  SCR_CMD     = 8'h5A;
    localparam logic [11:0] CODE_MAX    = 12'd255;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCR_ENABLE,
        REG_SAT_FREQUENCY,
        REG_SCR_CHANNEL,
        REG_SCR_USER_BAND,
        REG_SCR_PIN_ENABLE,
        REG_SCR_PIN
    } t_reg;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_WAIT,
        MODE_BANK,
        MODE_CODE
    } t_mode;

    typedef enum logic [3:0] {
        ACT_END,
        ACT_TONE_OFF,
        ACT_TONE_ON,
        ACT_13V,
        ACT_18V,
        ACT_MINI_A,
        ACT_MINI_B,
        ACT_WAIT,
        ACT_CODE,
        ACT_ERROR
    } t_action;

    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_WAIT,
        ERR_BANK,
        ERR_CODE,
        ERR_TOO_MANY,
        ERR_NO_BRACKET
    } t_err;

    typedef struct packed {
        logic        scr_enable;
        logic [15:0] sat_frequency;
        logic [2:0]  scr_channel;
        logic [15:0] scr_user_band;
        logic        scr_pin_enable;
        logic [7:0]  scr_pin;
    } t_cfg;

    // One plain result waiting in a job.
    typedef struct packed {
        t_action     action;
        logic [30:0] value;
        t_err        err;
    } t_slot;

    // One job from the front: an optional code run, then up to SLOTS plain results.
    typedef struct packed {
        logic                     run;
        logic [3:0]               run_n;
        logic [2:0]               bank;
        logic [BUF_MAX-1:0][7:0]  codes;
        logic [1:0]               n_slots;
        t_slot [SLOTS-1:0]        slots;
    } t_job;

endpackage

// ===== design/dcs_chr_if.sv =====
interface dcs_chr_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_of_string;

    modport source (output valid, output ch, output end_of_string, input ready);
    modport sink   (input valid, input ch, input end_of_string, output ready);
endinterface

// ===== design/dcs_res_if.sv =====
interface dcs_res_if;
    logic        valid;
    logic        ready;
    logic [3:0]  action;
    logic [30:0] value;
    logic [2:0]  code_index;
    logic [16:0] freq_offset;
    logic [2:0]  error_kind;
    logic        last;

    modport source (output valid, output action, output value, output code_index,
                    output freq_offset, output error_kind, output last, input ready);
    modport sink   (input valid, input action, input value, input code_index,
                    input freq_offset, input error_kind, input last, output ready);
endinterface

// ===== design/diseqc_command_string_sequencer.sv =====
// Satellite-switch command string sequencer.
// i_chr takes one character of a command string per request, with end_of_string
// on the final one. o_res gives the actions: tone, voltage, mini A/B, waits,
// code bytes one by one (SCR rewritten when enabled), end and errors; last
// marks the final result caused by a character.
// Configuration is written through i_cfg_wr_en / i_cfg_index / i_cfg_data while
// the block is idle (a duty of the user; the block does not enforce it); index
// order is scr_enable, sat_frequency, scr_channel, scr_user_band, scr_pin_enable, scr_pin.
// The first result of a character passes through the job queue and then the
// output register. A character is accepted every cycle while the job queue has room.
// The result stage gives one result per cycle while the receiver is ready; a
// code run gives up to MAX_CODES code bytes (five or six with SCR enabled).
// A two-entry job queue separates the parser from the result stage.
// Reset (synchronous, active low) clears configuration, parser state and the
// queue, and drops o_res.valid. When the receiver stalls, the result holds,
// the queue fills with two jobs and i_chr.ready then drops.
module diseqc_command_string_sequencer #(
    parameter int MAX_CODES = dcs_pkg::MAX_CODES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    dcs_chr_if.sink                          i_chr,
    dcs_res_if.source                        o_res,
    input  logic                             i_cfg_wr_en,
    input  logic [dcs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dcs_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import dcs_pkg::*;

    t_cfg r_cfg;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_valid;
    t_job f_job;
    t_job q_job;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_wr_en) begin
            case (t_reg'(i_cfg_index))
                REG_SCR_ENABLE:     r_cfg.scr_enable     <= i_cfg_data[0];
                REG_SAT_FREQUENCY:  r_cfg.sat_frequency  <= i_cfg_data;
                REG_SCR_CHANNEL:    r_cfg.scr_channel    <= i_cfg_data[2:0];
                REG_SCR_USER_BAND:  r_cfg.scr_user_band  <= i_cfg_data;
                REG_SCR_PIN_ENABLE: r_cfg.scr_pin_enable <= i_cfg_data[0];
                REG_SCR_PIN:        r_cfg.scr_pin        <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // Parser front.
    dcs_front #(
        .MAX_CODES (MAX_CODES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_chr   (i_chr),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_job   (f_job)
    );

    // Job queue.
    dcs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (f_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (q_job),
        .o_valid (q_valid)
    );

    // Result back end.
    dcs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (q_valid),
        .i_job   (q_job),
        .o_pop   (q_pop),
        .o_res   (o_res)
    );

endmodule

// ===== design/dcs_front.sv =====
module dcs_front #(
    parameter int MAX_CODES = dcs_pkg::MAX_CODES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  dcs_pkg::t_cfg i_cfg,
    dcs_chr_if.sink       i_chr,
    input  logic          i_full,
    output logic          o_push,
    output dcs_pkg::t_job o_job
);
    import dcs_pkg::*;

    localparam int IW = $clog2(MAX_CODES);
    localparam logic [3:0]  MAX_CNT  = 4'(MAX_CODES);
    localparam logic [34:0] WAIT_MAX = {4'd0, {31{1'b1}}};
    localparam logic [34:0] BANK_MAX = 35'd7;

    // Command characters.
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TONE_0  = 8'h74;  // t
    localparam logic [7:0] CH_TONE_1  = 8'h54;  // T
    localparam logic [7:0] CH_13V     = 8'h76;  // v
    localparam logic [7:0] CH_18V     = 8'h56;  // V
    localparam logic [7:0] CH_MINI_A  = 8'h41;  // A
    localparam logic [7:0] CH_MINI_B  = 8'h42;  // B
    localparam logic [7:0] CH_WAIT    = 8'h57;  // W
    localparam logic [7:0] CH_BANK    = 8'h53;  // S
    localparam logic [7:0] CH_OPEN    = 8'h5B;  // [
    localparam logic [7:0] CH_CLOSE   = 8'h5D;  // ]

    t_mode                       r_mode, n_mode;
    logic [30:0]                 r_acc, n_acc;
    logic                        r_digit, n_digit;
    logic [MAX_CODES-1:0][7:0]   r_buf, n_buf;
    logic [3:0]                  r_cnt, n_cnt;
    logic [2:0]                  r_bank, n_bank;
    logic                        r_bank_set, n_bank_set;
    logic                        r_stopped, n_stopped;

    logic        accept;
    logic        is_dig;
    logic        is_hex;
    logic [3:0]  hex_d;
    logic [34:0] dec_v;
    logic [11:0] hex_v;
    t_job        job;

    assign i_chr.ready = !i_full;
    assign accept      = i_chr.valid && !i_full;

    // Character classes and the next number value.
    always_comb begin
        is_dig = (i_chr.ch >= 8'h30) && (i_chr.ch <= 8'h39);
        is_hex = is_dig || ((i_chr.ch >= 8'h61) && (i_chr.ch <= 8'h66))
                        || ((i_chr.ch >= 8'h41) && (i_chr.ch <= 8'h46));
        hex_d  = is_dig ? i_chr.ch[3:0] : (i_chr.ch[3:0] + 4'd9);
        dec_v  = ({4'd0, r_acc} << 3) + ({4'd0, r_acc} << 1) + {31'd0, i_chr.ch[3:0]};
        hex_v  = {r_acc[7:0], hex_d};
    end

    // Parser: next state and the job this character causes.
    always_comb begin
        logic       do_idle;
        logic [1:0] ns;
        t_err       kind;
        n_mode     = r_mode;
        n_acc      = r_acc;
        n_digit    = r_digit;
        n_buf      = r_buf;
        n_cnt      = r_cnt;
        n_bank     = r_bank;
        n_bank_set = r_bank_set;
        n_stopped  = r_stopped;
        job        = '0;
        ns         = 2'd0;
        do_idle    = 1'b0;
        kind       = (r_mode == MODE_WAIT) ? ERR_WAIT : ERR_BANK;

        if (!r_stopped) begin
            case (r_mode)
                MODE_WAIT, MODE_BANK: begin
                    if (is_dig) begin
                        n_digit = 1'b1;
                        if ((r_mode == MODE_WAIT && dec_v > WAIT_MAX) ||
                            (r_mode == MODE_BANK && dec_v > BANK_MAX)) begin
                            job.slots[ns] = '{ACT_ERROR, 31'd0, kind};
                            ns = ns + 2'd1;
                            n_stopped = 1'b1;
                        end else begin
                            n_acc = dec_v[30:0];
                        end
                    end else if (!r_digit) begin
                        if (i_chr.ch != CH_SPACE) begin
                            job.slots[ns] = '{ACT_ERROR, 31'd0, kind};
                            ns = ns + 2'd1;
                            n_stopped = 1'b1;
                        end
                    end else begin
                        // The number ends here; the character is then a command.
                        if (r_mode == MODE_WAIT) begin
                            job.slots[ns] = '{ACT_WAIT, r_acc, ERR_NONE};
                            ns = ns + 2'd1;
                        end else if (!r_bank_set) begin
                            n_bank     = r_acc[2:0];
                            n_bank_set = 1'b1;
                        end
                        n_mode  = MODE_IDLE;
                        n_acc   = '0;
                        n_digit = 1'b0;
                        do_idle = 1'b1;
                    end
                end
                MODE_CODE: begin
                    if (is_hex) begin
                        if (!r_digit && r_cnt >= MAX_CNT) begin
                            job.slots[ns] = '{ACT_ERROR, 31'd0, ERR_TOO_MANY};
                            ns = ns + 2'd1;
                            n_stopped = 1'b1;
                        end else begin
                            n_digit = 1'b1;
                            if (hex_v > CODE_MAX) begin
                                job.slots[ns] = '{ACT_ERROR, 31'd0, ERR_CODE};
                                ns = ns + 2'd1;
                                n_stopped = 1'b1;
                            end else begin
                                n_acc = {19'd0, hex_v};
                            end
                        end
                    end else if (i_chr.ch == CH_SPACE || i_chr.ch == CH_CLOSE) begin
                        if (r_digit) begin
                            n_buf[r_cnt[IW-1:0]] = r_acc[7:0];
                            n_cnt   = r_cnt + 4'd1;
                            n_acc   = '0;
                            n_digit = 1'b0;
                        end
                        if (i_chr.ch == CH_CLOSE) begin
                            job.run  = 1'b1;
                            job.bank = r_bank;
                            for (int i = 0; i < MAX_CODES; i++) begin
                                job.codes[i] = n_buf[i];
                            end
                            if (i_cfg.scr_enable) begin
                                job.run_n = i_cfg.scr_pin_enable ? 4'd6 : 4'd5;
                            end else begin
                                job.run_n = n_cnt;
                            end
                            n_mode = MODE_IDLE;
                        end
                    end else begin
                        job.slots[ns] = '{ACT_ERROR, 31'd0, ERR_CODE};
                        ns = ns + 2'd1;
                        n_stopped = 1'b1;
                    end
                end
                default: begin
                    do_idle = 1'b1;
                end
            endcase

            // Command characters outside of numbers and code runs.
            if (do_idle) begin
                case (i_chr.ch)
                    CH_SPACE: begin
                    end
                    CH_TONE_0: begin
                        job.slots[ns] = '{ACT_TONE_OFF, 31'd0, ERR_NONE};
                        ns = ns + 2'd1;
                    end
                    CH_TONE_1: begin
                        job.slots[ns] = '{ACT_TONE_ON, 31'd0, ERR_NONE};
                        ns = ns + 2'd1;
                    end
                    CH_13V: begin
                        job.slots[ns] = '{ACT_13V, 31'd0, ERR_NONE};
                        ns = ns + 2'd1;
                    end
                    CH_18V: begin
                        job.slots[ns] = '{ACT_18V, 31'd0, ERR_NONE};
                        ns = ns + 2'd1;
                    end
                    CH_MINI_A: begin
                        job.slots[ns] = '{ACT_MINI_A, 31'd0, ERR_NONE};
                        ns = ns + 2'd1;
                    end
                    CH_MINI_B: begin
                        job.slots[ns] = '{ACT_MINI_B, 31'd0, ERR_NONE};
                        ns = ns + 2'd1;
                    end
                    CH_WAIT: begin
                        n_mode  = MODE_WAIT;
                        n_acc   = '0;
                        n_digit = 1'b0;
                    end
                    CH_BANK: begin
                        n_mode  = MODE_BANK;
                        n_acc   = '0;
                        n_digit = 1'b0;
                    end
                    CH_OPEN: begin
                        n_buf   = '0;
                        n_cnt   = '0;
                        n_acc   = '0;
                        n_digit = 1'b0;
                        n_mode  = MODE_CODE;
                    end
                    default: begin
                        job.slots[ns] = '{ACT_END, 31'd0, ERR_NONE};
                        ns = ns + 2'd1;
                        n_stopped = 1'b1;
                    end
                endcase
            end
        end

        // End of string: close a pending number, report an unclosed run as an error, report end, start over.
        if (i_chr.end_of_string) begin
            if (!n_stopped) begin
                if (n_mode == MODE_WAIT || n_mode == MODE_BANK) begin
                    if (n_digit) begin
                        if (n_mode == MODE_WAIT) begin
                            job.slots[ns] = '{ACT_WAIT, n_acc, ERR_NONE};
                            ns = ns + 2'd1;
                        end
                    end else begin
                        job.slots[ns] = '{ACT_ERROR, 31'd0,
                                          (n_mode == MODE_WAIT) ? ERR_WAIT : ERR_BANK};
                        ns = ns + 2'd1;
                        n_stopped = 1'b1;
                    end
                end else if (n_mode == MODE_CODE) begin
                    job.slots[ns] = '{ACT_ERROR, 31'd0, ERR_NO_BRACKET};
                    ns = ns + 2'd1;
                    n_stopped = 1'b1;
                end
                if (!n_stopped) begin
                    job.slots[ns] = '{ACT_END, 31'd0, ERR_NONE};
                    ns = ns + 2'd1;
                end
            end
            n_mode     = MODE_IDLE;
            n_acc      = '0;
            n_digit    = 1'b0;
            n_buf      = '0;
            n_cnt      = '0;
            n_bank     = '0;
            n_bank_set = 1'b0;
            n_stopped  = 1'b0;
        end

        job.n_slots = ns;
    end

    assign o_job  = job;
    assign o_push = accept && ((job.run && job.run_n != 4'd0) || job.n_slots != 2'd0);

    // Parser state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_IDLE;
            r_acc      <= '0;
            r_digit    <= 1'b0;
            r_buf      <= '0;
            r_cnt      <= '0;
            r_bank     <= '0;
            r_bank_set <= 1'b0;
            r_stopped  <= 1'b0;
        end else if (accept) begin
            r_mode     <= n_mode;
            r_acc      <= n_acc;
            r_digit    <= n_digit;
            r_buf      <= n_buf;
            r_cnt      <= n_cnt;
            r_bank     <= n_bank;
            r_bank_set <= n_bank_set;
            r_stopped  <= n_stopped;
        end
    end

endmodule

// ===== design/dcs_queue.sv =====
module dcs_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dcs_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output dcs_pkg::t_job o_job,
    output logic          o_valid
);
    import dcs_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_job          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Job storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

// ===== design/dcs_back.sv =====
module dcs_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  dcs_pkg::t_cfg i_cfg,
    input  logic          i_valid,
    input  dcs_pkg::t_job i_job,
    output logic          o_pop,
    dcs_res_if.source     o_res
);
    import dcs_pkg::*;

    localparam logic [15:0] T_LO   = 16'(SCR_T_BASE);
    localparam logic [15:0] T_HI   = 16'(SCR_T_BASE + SCR_T_LIMIT);
    localparam logic [4:0]  RES_MAX = 5'(BUF_MAX);

    // SCR tuning word, derived from configuration only.
    logic        r_t_ok;
    logic [9:0]  r_t;
    logic [16:0] r_toff;

    // Position within the head job and the output register.
    logic [3:0]  r_pos;
    logic        r_valid;
    t_action     r_act;
    logic [30:0] r_val;
    logic [2:0]  r_idx;
    logic [16:0] r_off;
    t_err        r_err;
    logic        r_last;

    logic [17:0] sum;
    logic [15:0] s;
    logic        f_zero;
    logic        in_rng;
    logic [9:0]  t;
    logic [17:0] num;
    logic [16:0] toff;

    logic        adv;
    logic [4:0]  total_raw;
    logic [3:0]  total;
    logic        last;
    logic        is_byte;
    logic [2:0]  bi;
    logic [1:0]  sidx;
    logic [7:0]  code;
    t_slot       sl;

    // Tuning word and frequency offset.
    always_comb begin
        sum    = {2'd0, i_cfg.sat_frequency} + {2'd0, i_cfg.scr_user_band} + 18'd2;
        s      = sum[17:2];
        f_zero = (i_cfg.sat_frequency == 16'd0);
        in_rng = (s >= T_LO) && (s < T_HI);
        t      = f_zero ? 10'd0 : 10'(s - T_LO);
        num    = {s, 2'b00};
        if (!f_zero && in_rng && t != 10'd0 && num > {2'd0, i_cfg.sat_frequency}) begin
            toff = 17'(num - {2'd0, i_cfg.sat_frequency});
        end else begin
            toff = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t_ok <= f_zero || in_rng;
        r_t    <= t;
        r_toff <= toff;
    end

    // Select the result at the current position of the head job.
    always_comb begin
        total_raw = {1'b0, i_job.run_n} + {3'd0, i_job.n_slots};
        total     = (total_raw > RES_MAX) ? RES_MAX[3:0] : total_raw[3:0];
        last      = ((r_pos + 4'd1) == total);
        is_byte   = (r_pos < i_job.run_n);
        bi        = r_pos[2:0];
        sidx      = 2'(r_pos - i_job.run_n);
        sl        = i_job.slots[sidx];
        code      = i_job.codes[bi];
        if (i_cfg.scr_enable) begin
            case (bi)
                3'd2: code = i_cfg.scr_pin_enable ? SCR_CMD_PIN : SCR_CMD;
                3'd3: begin
                    if (r_t_ok) begin
                        code = {i_cfg.scr_channel,
                                (r_t != 10'd0) ? i_job.bank : 3'd0, r_t[9:8]};
                    end
                end
                3'd4: begin
                    if (r_t_ok) begin
                        code = r_t[7:0];
                    end
                end
                3'd5: begin
                    if (i_cfg.scr_pin_enable) begin
                        code = i_cfg.scr_pin;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign adv   = !r_valid || o_res.ready;
    assign o_pop = adv && i_valid && last;

    // Output register and position counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= '0;
        end else if (adv) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_pos <= last ? 4'd0 : r_pos + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_valid) begin
            r_last <= last;
            if (is_byte) begin
                r_act <= ACT_CODE;
                r_val <= {23'd0, code};
                r_idx <= bi;
                r_off <= ((r_pos + 4'd1) == i_job.run_n && i_cfg.scr_enable) ? r_toff : '0;
                r_err <= ERR_NONE;
            end else begin
                r_act <= sl.action;
                r_val <= sl.value;
                r_idx <= '0;
                r_off <= '0;
                r_err <= sl.err;
            end
        end
    end

    assign o_res.valid       = r_valid;
    assign o_res.action      = r_act;
    assign o_res.value       = r_val;
    assign o_res.code_index  = r_idx;
    assign o_res.freq_offset = r_off;
    assign o_res.error_kind  = r_err;
    assign o_res.last        = r_last;

endmodule

// ===== design/dcs_checker.sv =====
`include "diseqc_command_string_sequencer_assert.svh"

module dcs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [3:0]  i_action,
    input logic [30:0] i_value,
    input logic [2:0]  i_code_index,
    input logic [16:0] i_freq_offset,
    input logic [2:0]  i_error_kind,
    input logic        i_last
);
    import dcs_pkg::*;

    // A stalled result stays in place.
    `DCS_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_action) && $stable(i_value) && $stable(i_code_index) && $stable(i_freq_offset) && $stable(i_error_kind) && $stable(i_last), "result changed while stalled")

    // Reset empties the result stage.
    `DCS_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n, !i_out_valid, "result valid after reset")

    // An end or an error is always the final result of its character.
    `DCS_ASSERT_NOW(a_stop_last, i_clk, i_rst_n, i_out_valid && (i_action == ACT_END || i_action == ACT_ERROR), i_last, "end or error not marked last")

    // An error kind comes with an error action and only with it.
    `DCS_ASSERT_NOW(a_err_kind, i_clk, i_rst_n, i_out_valid, (i_action == ACT_ERROR) == (i_error_kind != ERR_NONE), "error kind and action disagree")

    // The frequency offset rides only on code bytes.
    `DCS_ASSERT_NOW(a_off_code, i_clk, i_rst_n, i_out_valid && (i_freq_offset != 17'd0), i_action == ACT_CODE, "offset outside a code byte")

endmodule

bind diseqc_command_string_sequencer dcs_checker u_dcs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_action      (o_res.action),
    .i_value       (o_res.value),
    .i_code_index  (o_res.code_index),
    .i_freq_offset (o_res.freq_offset),
    .i_error_kind  (o_res.error_kind),
    .i_last        (o_res.last)
);
